>>> hdl/jrq_pkg.sv
// Shared types and constants for the joystick region quantizer.
// No dependencies; imported by every module of the block.
package jrq_pkg;

  // Command codes carried with each input item
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WIDEN  = 2'd1,
    CMD_CENTRE = 2'd2,
    CMD_STEP   = 2'd3
  } cmd_t;

  localparam int REGION_W = 4;
  typedef logic [REGION_W-1:0] region_t;

  // Region codes, full negative deflection up to full positive
  localparam region_t R_NEG_FULL = 4'd0;
  localparam region_t R_NEG_2    = 4'd1;
  localparam region_t R_NEG_1    = 4'd2;
  localparam region_t R_NEG_0    = 4'd3;
  localparam region_t R_CENTRE   = 4'd4;
  localparam region_t R_POS_0    = 4'd5;
  localparam region_t R_POS_1    = 4'd6;
  localparam region_t R_POS_2    = 4'd7;
  localparam region_t R_POS_FULL = 4'd8;

  // Number of bands the calibrated span is split into
  localparam int STEP_DIVISOR = 7;

endpackage

>>> hdl/jrq_state.sv
// Calibration state of both axes: held samples, centres, bounds, steps.
// Runs one command per transfer and registers the selected axis operands.
// Depends on jrq_pkg.
module jrq_state #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  jrq_pkg::cmd_t     cmd,
  input  logic [W-1:0]      x_sample,
  input  logic [W-1:0]      y_sample,
  input  logic              axis_select,
  output logic [W-1:0]      held_r,
  output logic [W-1:0]      centre_r,
  output logic [W-3:0]      step_r
);
  import jrq_pkg::*;

  localparam int STEP_W = W - 2;
  localparam int SHIFT  = W + 3;
  localparam int PROD_W = 2 * W + 1;
  // Rounded-up reciprocal of the divisor, exact for every W-bit span
  localparam int RECIP_I = ((1 << SHIFT) + STEP_DIVISOR - 1) / STEP_DIVISOR;
  localparam logic [W:0] RECIP = (W + 1)'(RECIP_I);

  logic [W-1:0]      x_held_r, y_held_r, x_held_nxt, y_held_nxt;
  logic [W-1:0]      x_centre_r, y_centre_r, x_centre_nxt, y_centre_nxt;
  logic [W-1:0]      x_low_r, y_low_r, x_low_nxt, y_low_nxt;
  logic [W-1:0]      x_high_r, y_high_r, x_high_nxt, y_high_nxt;
  logic [STEP_W-1:0] x_step_r, y_step_r, x_step_nxt, y_step_nxt;
  logic [W-1:0]      held_nxt, centre_nxt;
  logic [STEP_W-1:0] step_nxt;

  // Span divided by seven through a constant reciprocal; zero if inverted
  function automatic logic [STEP_W-1:0] step_of(input logic [W-1:0] lo,
                                                input logic [W-1:0] hi);
    logic [W-1:0]      diff;
    logic [PROD_W-1:0] prod;
    diff = hi - lo;
    prod = PROD_W'(diff) * PROD_W'(RECIP);
    if (hi < lo) begin
      step_of = '0;
    end else begin
      step_of = prod[SHIFT +: STEP_W];
    end
  endfunction

  // Carry out the command on the current state
  always_comb begin
    x_held_nxt   = x_held_r;
    y_held_nxt   = y_held_r;
    x_centre_nxt = x_centre_r;
    y_centre_nxt = y_centre_r;
    x_low_nxt    = x_low_r;
    y_low_nxt    = y_low_r;
    x_high_nxt   = x_high_r;
    y_high_nxt   = y_high_r;
    x_step_nxt   = x_step_r;
    y_step_nxt   = y_step_r;
    unique case (cmd)
      CMD_SAMPLE: begin
        x_held_nxt = x_sample;
        y_held_nxt = y_sample;
      end
      CMD_WIDEN: begin
        x_held_nxt = x_sample;
        y_held_nxt = y_sample;
        if (x_sample > x_high_r) x_high_nxt = x_sample;
        if (x_sample < x_low_r)  x_low_nxt  = x_sample;
        if (y_sample > y_high_r) y_high_nxt = y_sample;
        if (y_sample < y_low_r)  y_low_nxt  = y_sample;
      end
      CMD_CENTRE: begin
        x_centre_nxt = x_held_r;
        y_centre_nxt = y_held_r;
      end
      CMD_STEP: begin
        x_step_nxt = step_of(x_low_r, x_high_r);
        y_step_nxt = step_of(y_low_r, y_high_r);
      end
      default: begin
      end
    endcase
  end

  // Pick the reported axis from the updated state
  always_comb begin
    if (axis_select) begin
      held_nxt   = y_held_nxt;
      centre_nxt = y_centre_nxt;
      step_nxt   = y_step_nxt;
    end else begin
      held_nxt   = x_held_nxt;
      centre_nxt = x_centre_nxt;
      step_nxt   = x_step_nxt;
    end
  end

  // Advance calibration state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_held_r   <= '0;
      y_held_r   <= '0;
      x_centre_r <= '0;
      y_centre_r <= '0;
      x_low_r    <= '1;
      y_low_r    <= '1;
      x_high_r   <= '0;
      y_high_r   <= '0;
      x_step_r   <= '0;
      y_step_r   <= '0;
    end else if (fire) begin
      x_held_r   <= x_held_nxt;
      y_held_r   <= y_held_nxt;
      x_centre_r <= x_centre_nxt;
      y_centre_r <= y_centre_nxt;
      x_low_r    <= x_low_nxt;
      y_low_r    <= y_low_nxt;
      x_high_r   <= x_high_nxt;
      y_high_r   <= y_high_nxt;
      x_step_r   <= x_step_nxt;
      y_step_r   <= y_step_nxt;
    end
  end

  // Hold the operands for the quantizer stage
  always_ff @(posedge clk) begin
    if (fire) begin
      held_r   <= held_nxt;
      centre_r <= centre_nxt;
      step_r   <= step_nxt;
    end
  end

endmodule

>>> hdl/jrq_quant.sv
// Region quantizer: compares a held sample against centre and step bands
// and registers the region code. Depends on jrq_pkg.
module jrq_quant #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              load,
  input  logic [W-1:0]      held,
  input  logic [W-1:0]      centre,
  input  logic [W-3:0]      step,
  output jrq_pkg::region_t  region_r
);
  import jrq_pkg::*;

  // Wide enough for centre plus or minus three steps without wrap
  localparam int QW = W + 2;

  logic signed [QW-1:0] v, c, d, half, d2, d3;
  region_t              region_nxt;

  assign v    = signed'(QW'(held));
  assign c    = signed'(QW'(centre));
  assign d    = signed'(QW'(step));
  assign half = signed'(QW'(step >> 1));
  assign d2   = d <<< 1;
  assign d3   = d + d2;

  // Dead zone first, then bands outward on each side
  always_comb begin
    priority if (v > c + half) begin
      priority if (v < c + d)  region_nxt = R_POS_0;
      else if (v < c + d2)     region_nxt = R_POS_1;
      else if (v < c + d3)     region_nxt = R_POS_2;
      else                     region_nxt = R_POS_FULL;
    end else if (v < c - half) begin
      priority if (v > c - d)  region_nxt = R_NEG_0;
      else if (v > c - d2)     region_nxt = R_NEG_1;
      else if (v > c - d3)     region_nxt = R_NEG_2;
      else                     region_nxt = R_NEG_FULL;
    end else begin
      region_nxt = R_CENTRE;
    end
  end

  // Hold the result until the output stage takes a new one
  always_ff @(posedge clk) begin
    if (load) begin
      region_r <= region_nxt;
    end
  end

endmodule

>>> hdl/joystick_region_quantizer.sv
// Top level of the joystick region quantizer: handshake and pipeline control.
// Instantiates jrq_state and jrq_quant; depends on jrq_pkg.
//
// Usage:
//   Input channel (in_*): command, both stick samples and an axis choice.
//   A transfer happens at an edge with in_valid high and in_stall low.
//   Result channel (out_*): one region code (0..8) per input item, in order.
//   Three register stages: input register, state update with operand
//   register, quantizer with result register. An item passes through them in
//   that order, and out_valid rises once it reaches the result register.
//   One item per cycle is sustained; the rate is set only by the receiver,
//   each stage refilling as it empties.
//   The command takes effect before the region of the chosen axis is read.
//   Reset (rst_n low, synchronous) empties all stages, clears held samples,
//   centres, high bounds and steps, and sets low bounds to all ones.
//   A stall on out_stall holds out_region steady and backs up through the
//   stages; in_stall rises once the input register can no longer drain.
module joystick_region_quantizer #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic [SAMPLE_BITS-1:0] in_x_sample,
  input  logic [SAMPLE_BITS-1:0] in_y_sample,
  input  logic                   in_axis_select,
  output logic                   out_valid,
  input  logic                   out_stall,
  output jrq_pkg::region_t       out_region
);
  import jrq_pkg::*;

  logic                   a_valid_r, b_valid_r, out_valid_r;
  cmd_t                   cmd_r;
  logic [SAMPLE_BITS-1:0] x_sample_r, y_sample_r;
  logic                   axis_r;
  logic                   out_move, b_move, a_fire;
  logic [SAMPLE_BITS-1:0] held, centre;
  logic [SAMPLE_BITS-3:0] step;

  // Each stage may load when empty or when its content moves on
  assign out_move = !out_valid_r || !out_stall;
  assign b_move   = !b_valid_r || out_move;
  assign a_fire   = a_valid_r && b_move;
  assign in_stall = a_valid_r && !b_move;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) a_valid_r   <= in_valid;
      if (b_move)    b_valid_r   <= a_valid_r;
      if (out_move)  out_valid_r <= b_valid_r;
    end
  end

  // Capture the input item on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r      <= cmd_t'(in_command);
      x_sample_r <= in_x_sample;
      y_sample_r <= in_y_sample;
      axis_r     <= in_axis_select;
    end
  end

  jrq_state #(.W(SAMPLE_BITS)) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (a_fire),
    .cmd         (cmd_r),
    .x_sample    (x_sample_r),
    .y_sample    (y_sample_r),
    .axis_select (axis_r),
    .held_r      (held),
    .centre_r    (centre),
    .step_r      (step)
  );

  jrq_quant #(.W(SAMPLE_BITS)) u_quant (
    .clk      (clk),
    .load     (out_move && b_valid_r),
    .held     (held),
    .centre   (centre),
    .step     (step),
    .region_r (out_region)
  );

  assign out_valid = out_valid_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for joystick_region_quantizer: directed and random items
// checked against an in-bench predictor of the region ladder.
// Depends on jrq_pkg and the joystick_region_quantizer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jrq_pkg::*;

  localparam int SAMPLE_BITS    = 8;
  localparam int STEP_BITS      = SAMPLE_BITS - 2;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ROUNDS         = 15;
  localparam int ROUND_ITEMS    = 82;
  localparam int MAX_REPORTS    = 40;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [STEP_BITS-1:0]   band_t;

  typedef struct {
    region_t     region;
    int unsigned index;
  } region_expect_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  logic [1:0] in_command = CMD_SAMPLE;
  sample_t in_x_sample = '0;
  sample_t in_y_sample = '0;
  logic    in_axis_select = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  region_t out_region;

  // Predictor state, tracked alongside the block
  sample_t x_hold, y_hold;
  sample_t x_mid, y_mid;
  sample_t x_floor, x_ceil, y_floor, y_ceil;
  band_t   x_band, y_band;

  region_expect_t pending_regions[$];
  region_expect_t head_expect;
  int unsigned    accepted_count = 0;
  int             error_count = 0;
  int             idle_cycles = 0;
  bit             in_idle_on = 1'b1;

  joystick_region_quantizer #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_x_sample    (in_x_sample),
    .in_y_sample    (in_y_sample),
    .in_axis_select (in_axis_select),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_region     (out_region)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Step size from the calibrated span; zero when the bounds are inverted
  function automatic band_t span_step(sample_t lo, sample_t hi);
    if (hi < lo) return '0;
    return band_t'((int'(hi) - int'(lo)) / STEP_DIVISOR);
  endfunction

  // Place a held value on the nine-band ladder around its centre
  function automatic region_t ladder_region(sample_t held, sample_t centre, band_t step);
    int v, c, d, half;
    v = int'(held);
    c = int'(centre);
    d = int'(step);
    half = d / 2;
    if (v > c + half) begin
      if (v < c + d) return R_POS_0;
      if (v < c + 2 * d) return R_POS_1;
      if (v < c + 3 * d) return R_POS_2;
      return R_POS_FULL;
    end
    if (v < c - half) begin
      if (v > c - d) return R_NEG_0;
      if (v > c - 2 * d) return R_NEG_1;
      if (v > c - 3 * d) return R_NEG_2;
      return R_NEG_FULL;
    end
    return R_CENTRE;
  endfunction

  // Apply one command to the tracked state, then report the chosen axis
  function automatic region_t next_region(cmd_t cmd, sample_t xs, sample_t ys, logic axis);
    case (cmd)
      CMD_SAMPLE: begin
        x_hold = xs;
        y_hold = ys;
      end
      CMD_WIDEN: begin
        x_hold = xs;
        y_hold = ys;
        if (x_hold > x_ceil) x_ceil = x_hold;
        if (x_hold < x_floor) x_floor = x_hold;
        if (y_hold > y_ceil) y_ceil = y_hold;
        if (y_hold < y_floor) y_floor = y_hold;
      end
      CMD_CENTRE: begin
        x_mid = x_hold;
        y_mid = y_hold;
      end
      default: begin
        x_band = span_step(x_floor, x_ceil);
        y_band = span_step(y_floor, y_ceil);
      end
    endcase
    if (axis) return ladder_region(y_hold, y_mid, y_band);
    return ladder_region(x_hold, x_mid, x_band);
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Track both channels: predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      x_hold = '0;
      y_hold = '0;
      x_mid = '0;
      y_mid = '0;
      x_floor = '1;
      y_floor = '1;
      x_ceil = '0;
      y_ceil = '0;
      x_band = '0;
      y_band = '0;
    end else begin
      if (in_valid && !in_stall) begin
        head_expect.region = next_region(cmd_t'(in_command), in_x_sample, in_y_sample,
                                         in_axis_select);
        head_expect.index = accepted_count;
        pending_regions.push_back(head_expect);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_regions.size() == 0) begin
          report_mismatch($sformatf("region %0d transferred with nothing expected",
                                    out_region));
        end else begin
          head_expect = pending_regions.pop_front();
          if (out_region !== head_expect.region)
            report_mismatch($sformatf("item %0d: region %0d, expected %0d",
                                      head_expect.index, out_region, head_expect.region));
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int rand_offset(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic sample_t clamp_sample(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return sample_t'(v);
  endfunction

  // Stall the result channel: short and long stalls, with long free-running stretches
  initial begin : result_stall_driver
    int r;
    wait (rst_n);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_stall <= 1'b0;
      if (r < 15) begin
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b1;
        if (r < 75) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(6, 30)) @(posedge clk);
      end
    end
  end

  // Drive one item and hold it until the transfer
  task automatic send_item(cmd_t cmd, sample_t xs, sample_t ys, logic axis);
    int gap;
    gap = pick_gap(in_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command <= cmd;
    in_x_sample <= xs;
    in_y_sample <= ys;
    in_axis_select <= axis;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Uncalibrated state: step is zero, inverted bounds keep it zero
  task automatic test_zero_step();
    send_item(CMD_SAMPLE, 8'h00, 8'h00, 1'b0);
    send_item(CMD_SAMPLE, 8'h01, 8'hFF, 1'b1);
    send_item(CMD_STEP, 8'hAA, 8'h55, 1'b0);
    send_item(CMD_CENTRE, 8'hFF, 8'hFF, 1'b1);
    send_item(CMD_SAMPLE, 8'h00, 8'hFE, 1'b0);
  endtask

  // Narrow calibration around 128, then walk every band, reporting the two axes in turn
  task automatic test_calibrated_bands();
    sample_t sweep [9];
    int i;
    sweep = '{8'd128, 8'd131, 8'd133, 8'd137, 8'd255, 8'd125, 8'd122, 8'd118, 8'd0};
    send_item(CMD_WIDEN, 8'd114, 8'd142, 1'b0);
    send_item(CMD_WIDEN, 8'd142, 8'd114, 1'b1);
    send_item(CMD_SAMPLE, 8'd128, 8'd128, 1'b0);
    send_item(CMD_CENTRE, 8'h5A, 8'hA5, 1'b1);
    send_item(CMD_STEP, 8'hC3, 8'h3C, 1'b0);
    for (i = 0; i < 9; i++)
      send_item(CMD_SAMPLE, sweep[i], sweep[8 - i], logic'(i % 2));
  endtask

  // One calibration round: widen, sample, centre, step, then mostly samples across the bands
  task automatic run_round(int spread);
    int i, r, x_span, y_span;
    cmd_t cmd;
    in_idle_on = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(3, 8))
      send_item(CMD_WIDEN, clamp_sample(128 + rand_offset(spread)),
                clamp_sample(128 + rand_offset(spread)), logic'($urandom_range(0, 1)));
    send_item(CMD_SAMPLE, clamp_sample(128 + rand_offset(spread)),
              clamp_sample(128 + rand_offset(spread)), logic'($urandom_range(0, 1)));
    send_item(CMD_CENTRE, sample_t'($urandom), sample_t'($urandom),
              logic'($urandom_range(0, 1)));
    send_item(CMD_STEP, sample_t'($urandom), sample_t'($urandom),
              logic'($urandom_range(0, 1)));
    for (i = 0; i < ROUND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      x_span = 4 * int'(x_band) + 3;
      y_span = 4 * int'(y_band) + 3;
      if (r < 78) begin
        send_item(CMD_SAMPLE, clamp_sample(int'(x_mid) + rand_offset(x_span)),
                  clamp_sample(int'(y_mid) + rand_offset(y_span)),
                  logic'($urandom_range(0, 1)));
      end else if (r < 88) begin
        send_item(CMD_WIDEN, clamp_sample(128 + rand_offset(spread)),
                  clamp_sample(128 + rand_offset(spread)), logic'($urandom_range(0, 1)));
      end else begin
        // Noise: any command, full-range samples except where they would widen early
        cmd = cmd_t'($urandom_range(0, 3));
        if (cmd == CMD_WIDEN)
          send_item(cmd, clamp_sample(128 + rand_offset(spread)),
                    clamp_sample(128 + rand_offset(spread)), logic'($urandom_range(0, 1)));
        else
          send_item(cmd, sample_t'($urandom), sample_t'($urandom),
                    logic'($urandom_range(0, 1)));
      end
    end
  endtask

  // Widen the calibration span round by round
  task automatic test_random_calibration();
    int k;
    for (k = 0; k < ROUNDS; k++) run_round(16 + 8 * k);
    in_idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_step();
    test_calibrated_bands();
    test_random_calibration();
    in_valid <= 1'b0;
    // Drain outstanding results, then let the pipeline settle
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hdl/jrq_pkg.sv
hdl/jrq_state.sv
hdl/jrq_quant.sv
hdl/joystick_region_quantizer.sv
tb/testbench.sv
